/* hdl/bardec_pkg.sv */
// bardec_pkg: shared types and constants of the bus address range decoder
// operation, status and item class codes, queue item and window entry layouts
// no dependencies
`timescale 1ns / 1ps

package bardec_pkg;

  localparam int WINDOW_SLOTS_DEF = 8;
  localparam int DATA_W           = 32;
  localparam int QUEUE_DEPTH      = 2;

  // register word index on the configuration port
  localparam logic REG_BUS_ENABLE = 1'b0;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_OVERLAP  = 3'd2,
    ST_DISABLED = 3'd3,
    ST_NODEV    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CLS_ADD,
    CLS_READ,
    CLS_WRITE,
    CLS_NODEV,
    CLS_DISABLED
  } item_cls_t;

  typedef struct packed {
    item_cls_t          cls;
    logic [DATA_W-1:0]  address;
    logic [DATA_W-1:0]  limit;
    logic               rd;
    logic               wr;
    logic [DATA_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] last;
    logic              readable;
    logic              writable;
  } window_t;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_t;

endpackage

/* hdl/bus_address_range_decoder.sv */
// bus_address_range_decoder: top level, configuration register and the two halves
// depends on bardec_pkg, bardec_front, bardec_back
`timescale 1ns / 1ps

//  channel   handshake                         payload
//  config    psel/penable/pwrite, pready = 1   paddr, pwdata, prdata (bus_enable)
//  request   start accepted when busy is low   operation, address, window_limit,
//                                              supports_read, supports_write, write_value
//  result    done, one cycle, no back-pressure status, device_select, forward_address,
//                                              forward_value, is_write
//
//  a request is registered into a two-entry queue and waits at its head until the back end is idle
//  unused-code, bus-disabled and table-full requests raise done the cycle after leaving the queue
//  add and access requests scan the window table one entry per cycle out of a
//  registered-read ram, stopping at the first hit or after the last entry misses
//  busy rises only while the queue is full; reset clears the queue, the window count and done
//  table contents are not cleared, entries at or above the count are never compared

module bus_address_range_decoder import bardec_pkg::*; #(
  parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // request side
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation,
  input  logic [DATA_W-1:0] address,
  input  logic [DATA_W-1:0] window_limit,
  input  logic              supports_read,
  input  logic              supports_write,
  input  logic [DATA_W-1:0] write_value,
  // result side
  output logic              done,
  output logic [2:0]        status,
  output logic [2:0]        device_select,
  output logic [DATA_W-1:0] forward_address,
  output logic [DATA_W-1:0] forward_value,
  output logic              is_write
);

  logic        bus_enable;
  logic        cfg_write;
  queue_head_t head;
  logic        pop;

  // register decode on the word index, byte lane bits are ignored
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_BUS_ENABLE) ? 32'(bus_enable) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_enable <= 1'b1;
    end else if (cfg_write && (paddr[2] == REG_BUS_ENABLE)) begin
      bus_enable <= pwdata[0];
    end
  end

  // front end: classifies against bus_enable at intake, so a request is
  // judged by the setting in force when it was taken
  bardec_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .operation      (operation),
    .address        (address),
    .window_limit   (window_limit),
    .supports_read  (supports_read),
    .supports_write (supports_write),
    .write_value    (write_value),
    .bus_enable     (bus_enable),
    .busy           (busy),
    .head           (head),
    .pop            (pop)
  );

  // back end: owns the window table and the registered result
  bardec_back #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .pop             (pop),
    .done            (done),
    .status          (status),
    .device_select   (device_select),
    .forward_address (forward_address),
    .forward_value   (forward_value),
    .is_write        (is_write)
  );

endmodule

/* hdl/bardec_ram.sv */
// bardec_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module bardec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/bardec_front.sv */
// bardec_front: request intake, classification and the short queue to the back end
// depends on bardec_pkg
`timescale 1ns / 1ps

module bardec_front import bardec_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        operation,
  input  logic [DATA_W-1:0] address,
  input  logic [DATA_W-1:0] window_limit,
  input  logic              supports_read,
  input  logic              supports_write,
  input  logic [DATA_W-1:0] write_value,
  input  logic              bus_enable,
  output logic              busy,
  output queue_head_t       head,
  input  logic              pop
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

  op_t                op_code;
  item_cls_t          cls;
  item_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;
  logic               push;

  assign op_code = op_t'(operation);

  always_comb begin
    unique case (op_code)
      OP_ADD:   cls = CLS_ADD;
      OP_READ:  cls = CLS_READ;
      OP_WRITE: cls = CLS_WRITE;
      default:  cls = CLS_NODEV;
    endcase
    // disabled bus refuses everything except the unused code
    if (op_code != OP_UNUSED && !bus_enable) begin
      cls = CLS_DISABLED;
    end
  end

  assign busy = (fill == FULL_FILL);
  assign push = start && !busy;

  assign head.valid = (fill != '0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{cls:     cls,
                         address: address,
                         limit:   window_limit,
                         rd:      supports_read,
                         wr:      supports_write,
                         value:   write_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      fill <= fill + FILL_W'(push) - FILL_W'(pop);
    end
  end

endmodule

/* hdl/bardec_back.sv */
// bardec_back: window table and scan sequencer, produces one result per request
// depends on bardec_pkg and bardec_ram
`timescale 1ns / 1ps

module bardec_back import bardec_pkg::*; #(
  parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  queue_head_t       head,
  output logic              pop,
  output logic              done,
  output logic [2:0]        status,
  output logic [2:0]        device_select,
  output logic [DATA_W-1:0] forward_address,
  output logic [DATA_W-1:0] forward_value,
  output logic              is_write
);

  localparam int IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);
  localparam int WIN_W = $bits(window_t);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(WINDOW_SLOTS);

  back_state_t        state;
  back_state_t        state_next;
  item_t              cur;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   chk_idx;
  logic               chk_vld;
  logic               issue_en;
  logic               hit;
  logic               miss;
  logic               acc_hit;
  logic               ovl_hit;
  logic               needs_scan;
  logic               finish;
  logic               ram_we;
  window_t            win;
  logic [WIN_W-1:0]   ram_rdata;
  status_t            res_status;
  logic [IDX_W-1:0]   res_idx;
  logic [DATA_W-1:0]  res_addr;
  logic [DATA_W-1:0]  res_value;
  logic               res_write;

  bardec_ram #(
    .WIDTH (WIN_W),
    .DEPTH (WINDOW_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (WIN_W'({cur.address, cur.limit, cur.rd, cur.wr})),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign win = window_t'(ram_rdata);

  // one entry read per cycle, compared the cycle after
  assign issue_en = (state == BK_SCAN) && (scan_idx < count);
  assign acc_hit  = (cur.address >= win.base) && (cur.address <= win.last) &&
                    ((cur.cls == CLS_WRITE) ? win.writable : win.readable);
  assign ovl_hit  = (cur.address <= win.last) && (win.base <= cur.limit);
  assign hit      = chk_vld && ((cur.cls == CLS_ADD) ? ovl_hit : acc_hit);
  assign miss     = (state == BK_SCAN) && !issue_en && !hit;

  assign needs_scan = (head.item.cls == CLS_READ) || (head.item.cls == CLS_WRITE) ||
                      ((head.item.cls == CLS_ADD) && (count != SLOTS_CNT));

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (head.valid && needs_scan) begin
        state_next = BK_SCAN;
      end
      BK_SCAN: if (hit || miss) begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    finish     = 1'b0;
    ram_we     = 1'b0;
    count_next = count;
    res_status = ST_OK;
    res_idx    = '0;
    res_addr   = '0;
    res_value  = '0;
    res_write  = 1'b0;
    unique case (state)
      BK_IDLE: if (head.valid) begin
        pop = 1'b1;
        unique case (head.item.cls)
          CLS_NODEV: begin
            finish     = 1'b1;
            res_status = ST_NODEV;
          end
          CLS_DISABLED: begin
            finish     = 1'b1;
            res_status = ST_DISABLED;
          end
          CLS_ADD: if (count == SLOTS_CNT) begin
            finish     = 1'b1;
            res_status = ST_FULL;
          end
          default: ;
        endcase
      end
      BK_SCAN: if (hit) begin
        finish = 1'b1;
        if (cur.cls == CLS_ADD) begin
          res_status = ST_OVERLAP;
        end else begin
          res_idx   = chk_idx;
          res_addr  = cur.address;
          res_write = (cur.cls == CLS_WRITE);
          res_value = (cur.cls == CLS_WRITE) ? cur.value : '0;
        end
      end else if (miss) begin
        finish = 1'b1;
        if (cur.cls == CLS_ADD) begin
          ram_we     = 1'b1;
          res_idx    = count[IDX_W-1:0];
          count_next = count + CNT_W'(1);
        end else begin
          res_status = ST_NODEV;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.item;
    end
    chk_idx <= scan_idx[IDX_W-1:0];
    if (finish) begin
      status          <= res_status;
      device_select   <= 3'(res_idx);
      forward_address <= res_addr;
      forward_value   <= res_value;
      is_write        <= res_write;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      count    <= '0;
      scan_idx <= '0;
      chk_vld  <= 1'b0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= finish;
      if (state == BK_SCAN) begin
        scan_idx <= scan_idx + CNT_W'(issue_en);
        chk_vld  <= issue_en;
      end else begin
        scan_idx <= '0;
        chk_vld  <= 1'b0;
      end
    end
  end

endmodule

/* hdl/bardec_checker.sv */
// bardec_checker: port level assertions for the bus address range decoder
// depends on bardec_pkg; bound to bus_address_range_decoder
`timescale 1ns / 1ps

module bardec_checker import bardec_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              busy,
  input logic              done,
  input logic [2:0]        status,
  input logic [2:0]        device_select,
  input logic [DATA_W-1:0] forward_address,
  input logic [DATA_W-1:0] forward_value,
  input logic              is_write
);

  // refused or missed requests carry nothing but the status
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |->
      (device_select == 3'd0) && (forward_address == '0) &&
      (forward_value == '0) && !is_write)
    else $error("failing result carries payload");

  // only writes forward data
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    done && !is_write |-> (forward_value == '0))
    else $error("non-write result forwards data");

  // a routed write is always a successful result
  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    done && is_write |-> (status == ST_OK))
    else $error("write flagged on failing result");

  // reset empties the queue and drops any pending result
  a_reset: assert property (@(posedge clk)
    rst |=> !done && !busy)
    else $error("result or busy after reset");

endmodule

bind bus_address_range_decoder bardec_checker u_bardec_checker (.*);
